// ===== hw/rtl/http_request_line_checker_unit_assert.svh =====
// Assertion macros for the request line checker.
// Expects clk and rst_n in scope at every use.
`ifndef HTTP_REQUEST_LINE_CHECKER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HRLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request line checker: same-cycle check failed");

// Next-cycle implication.
`define HRLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request line checker: next-cycle check failed");

`endif

// ===== hw/rtl/hrlc_pkg.sv =====
// Shared types, codes and match tables for the request line checker.
// No dependencies.
package hrlc_pkg;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int METHOD_W  = 2;
    localparam int VERSION_W = 2;
    localparam int OFFSET_W  = 13;
    localparam int LIMIT_W   = 13;

    localparam logic [LIMIT_W-1:0] PATH_LIMIT_RESET = 13'd4096;

    // Verdict codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FORBIDDEN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_IMPL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_VERSION   = 3'd5;

    localparam logic [METHOD_W-1:0] MC_UNKNOWN = 2'd0;
    localparam logic [METHOD_W-1:0] MC_GET     = 2'd1;
    localparam logic [METHOD_W-1:0] MC_POST    = 2'd2;
    localparam logic [METHOD_W-1:0] MC_HEAD    = 2'd3;

    localparam logic [VERSION_W-1:0] VC_UNKNOWN = 2'd0;
    localparam logic [VERSION_W-1:0] VC_HTTP10  = 2'd1;
    localparam logic [VERSION_W-1:0] VC_HTTP11  = 2'd2;
    localparam logic [VERSION_W-1:0] VC_UNSUPP  = 2'd3;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    // Method candidates: GET, POST, HEAD
    localparam logic [BYTE_W-1:0] METHOD_WORDS [3][4] = '{
        '{"G", "E", "T", 8'h00},
        '{"P", "O", "S", "T"},
        '{"H", "E", "A", "D"}
    };
    localparam logic [2:0] METHOD_LENS [3] = '{3'd3, 3'd4, 3'd4};
    localparam logic [2:0] MPOS_MAX = 3'd5;

    // Version candidates: 1.0, 1.1, 0.9, 2.0
    localparam logic [BYTE_W-1:0] VERSION_WORDS [4][8] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "0"},
        '{"H", "T", "T", "P", "/", "1", ".", "1"},
        '{"H", "T", "T", "P", "/", "0", ".", "9"},
        '{"H", "T", "T", "P", "/", "2", ".", "0"}
    };
    localparam logic [3:0] VPOS_END = 4'd8;
    localparam logic [3:0] VPOS_MAX = 4'd9;

    typedef struct packed {
        logic [2:0]          token_count;
        logic                inside_token;
        logic                line_ended;
        logic                pending_cr;
        logic [2:0]          m_live;
        logic [2:0]          m_pos;
        logic [3:0]          v_live;
        logic [3:0]          v_pos;
        logic [OFFSET_W-1:0] path_start;
        logic [LIMIT_W-1:0]  path_count;
        logic                path_slash_first;
        logic [1:0]          trav_prog;
        logic                trav_found;
        logic [1:0]          term_prog;
        logic                term_found;
        logic                zero_seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        token_count:      3'd0,
        inside_token:     1'b0,
        line_ended:       1'b0,
        pending_cr:       1'b0,
        m_live:           3'b111,
        m_pos:            3'd0,
        v_live:           4'b1111,
        v_pos:            4'd0,
        path_start:       13'd0,
        path_count:       13'd0,
        path_slash_first: 1'b0,
        trav_prog:        2'd0,
        trav_found:       1'b0,
        term_prog:        2'd0,
        term_found:       1'b0,
        zero_seen:        1'b0
    };

endpackage

// ===== hw/rtl/hrlc_stream_if.sv =====
// Valid/ready channels for request bytes and verdicts.
// Depends on hrlc_pkg.
interface hrlc_req_if import hrlc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface hrlc_res_if import hrlc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [METHOD_W-1:0]  method_code;
    logic [VERSION_W-1:0] version_code;
    logic [OFFSET_W-1:0]  path_offset;
    logic [LIMIT_W-1:0]   path_length;

    modport source (output valid, status, method_code, version_code, path_offset,
                    path_length, input ready);
    modport sink   (input valid, status, method_code, version_code, path_offset,
                    path_length, output ready);
endinterface

// ===== hw/rtl/hrlc_tracker.sv =====
// Running match state of the request checker: one byte per step.
// Depends on hrlc_pkg and the assertion macro header.
`include "http_request_line_checker_unit_assert.svh"

module hrlc_tracker import hrlc_pkg::*; #(
    parameter int MAX_REQUEST_BYTES = 8192,
    localparam int POS_W = $clog2(MAX_REQUEST_BYTES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               last,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [LIMIT_W-1:0] path_limit,
    output scan_state_t        scan_upd
);

    scan_state_t       state_reg;
    scan_state_t       state_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_upd;
    logic [OFFSET_W-1:0] pos_cur;
    logic [OFFSET_W-1:0] pos_prev;

    function automatic scan_state_t method_byte(scan_state_t s, logic [BYTE_W-1:0] b);
        scan_state_t n;
        n = s;
        for (int c = 0; c < 3; c++) begin
            if (s.m_pos >= METHOD_LENS[c] || b != METHOD_WORDS[c][s.m_pos[1:0]])
                n.m_live[c] = 1'b0;
        end
        if (s.m_pos < MPOS_MAX)
            n.m_pos = s.m_pos + 3'd1;
        return n;
    endfunction

    function automatic scan_state_t version_byte(scan_state_t s, logic [BYTE_W-1:0] b);
        scan_state_t n;
        n = s;
        for (int c = 0; c < 4; c++) begin
            if (s.v_pos[3] || b != VERSION_WORDS[c][s.v_pos[2:0]])
                n.v_live[c] = 1'b0;
        end
        if (s.v_pos < VPOS_MAX)
            n.v_pos = s.v_pos + 4'd1;
        return n;
    endfunction

    function automatic scan_state_t path_byte(scan_state_t s, logic [BYTE_W-1:0] b,
                                              logic [LIMIT_W-1:0] limit);
        scan_state_t n;
        n = s;
        if (s.path_count < limit)
            n.path_count = s.path_count + 13'd1;
        priority if (b == CH_DOT)
            n.trav_prog = (s.trav_prog != 2'd0) ? 2'd2 : 2'd1;
        else if (b == CH_SLASH && s.trav_prog == 2'd2)
        begin
            n.trav_found = 1'b1;
            n.trav_prog  = 2'd0;
        end
        else
            n.trav_prog = 2'd0;
        return n;
    endfunction

    function automatic scan_state_t line_byte(scan_state_t s, logic [BYTE_W-1:0] b,
                                              logic [OFFSET_W-1:0] pos,
                                              logic [LIMIT_W-1:0] limit);
        scan_state_t n;
        n = s;
        if (b == CH_SP)
            n.inside_token = 1'b0;
        else
        begin
            if (!s.inside_token)
            begin
                n.inside_token = 1'b1;
                if (s.token_count < 3'd4)
                    n.token_count = s.token_count + 3'd1;
                if (n.token_count == 3'd2)
                begin
                    n.path_start       = pos;
                    n.path_slash_first = (b == CH_SLASH);
                end
            end
            unique case (n.token_count)
                3'd1:    n = method_byte(n, b);
                3'd2:    n = path_byte(n, b, limit);
                3'd3:    n = version_byte(n, b);
                default: n = n;
            endcase
        end
        return n;
    endfunction

    // Search for CR LF CR LF anywhere in the buffer
    function automatic scan_state_t term_byte(scan_state_t s, logic [BYTE_W-1:0] b);
        scan_state_t n;
        n = s;
        if (b == (s.term_prog[0] ? CH_LF : CH_CR))
        begin
            if (s.term_prog == 2'd3)
            begin
                n.term_found = 1'b1;
                n.term_prog  = 2'd0;
            end
            else
                n.term_prog = s.term_prog + 2'd1;
        end
        else
            n.term_prog = (b == CH_CR) ? 2'd1 : 2'd0;
        return n;
    endfunction

    always_comb
    begin
        scan_upd = state_reg;
        pos_upd  = pos_reg;
        pos_cur  = OFFSET_W'(pos_reg);
        pos_prev = OFFSET_W'(pos_reg - POS_W'(1));
        if (!state_reg.zero_seen && pos_reg < POS_W'(MAX_REQUEST_BYTES))
        begin
            pos_upd = pos_reg + POS_W'(1);
            if (data_byte == CH_NUL)
                scan_upd.zero_seen = 1'b1;
            else
            begin
                scan_upd = term_byte(scan_upd, data_byte);
                if (!scan_upd.line_ended)
                begin
                    if (scan_upd.pending_cr && data_byte == CH_LF)
                    begin
                        scan_upd.pending_cr = 1'b0;
                        scan_upd.line_ended = 1'b1;
                    end
                    else
                    begin
                        // a CR not followed by LF is an ordinary token byte
                        if (scan_upd.pending_cr)
                        begin
                            scan_upd.pending_cr = 1'b0;
                            scan_upd = line_byte(scan_upd, CH_CR, pos_prev, path_limit);
                        end
                        if (data_byte == CH_CR)
                            scan_upd.pending_cr = 1'b1;
                        else
                            scan_upd = line_byte(scan_upd, data_byte, pos_cur, path_limit);
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        if (step)
        begin
            if (last)
            begin
                state_next = SCAN_RESET;
                pos_next   = '0;
            end
            else
            begin
                state_next = scan_upd;
                pos_next   = pos_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    `HRLC_ASSERT_NEXT(a_clear_after_last, step && last, state_reg == SCAN_RESET && pos_reg == '0)
    `HRLC_ASSERT_NOW(a_cr_closed_by_line_end, state_reg.line_ended, !state_reg.pending_cr)
    `HRLC_ASSERT_NOW(a_pos_saturates, 1'b1, pos_reg <= POS_W'(MAX_REQUEST_BYTES))

endmodule

// ===== hw/rtl/hrlc_verdict.sv =====
// Verdict decode and result register of the request checker.
// Depends on hrlc_pkg, hrlc_stream_if and the assertion macro header.
`include "http_request_line_checker_unit_assert.svh"

module hrlc_verdict import hrlc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  scan_state_t        scan_upd,
    input  logic [LIMIT_W-1:0] path_limit,
    hrlc_res_if.source         res
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [METHOD_W-1:0]  method_reg;
    logic [VERSION_W-1:0] version_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [LIMIT_W-1:0]   length_reg;

    logic [METHOD_W-1:0]  mc;
    logic [VERSION_W-1:0] vc;
    logic [STATUS_W-1:0]  status_next;
    logic                 bad;

    always_comb
    begin
        priority if (scan_upd.m_live[0] && scan_upd.m_pos == METHOD_LENS[0])
            mc = MC_GET;
        else if (scan_upd.m_live[1] && scan_upd.m_pos == METHOD_LENS[1])
            mc = MC_POST;
        else if (scan_upd.m_live[2] && scan_upd.m_pos == METHOD_LENS[2])
            mc = MC_HEAD;
        else
            mc = MC_UNKNOWN;

        priority if (scan_upd.v_pos != VPOS_END)
            vc = VC_UNKNOWN;
        else if (scan_upd.v_live[0])
            vc = VC_HTTP10;
        else if (scan_upd.v_live[1])
            vc = VC_HTTP11;
        else if (scan_upd.v_live[3:2] != 2'b00)
            vc = VC_UNSUPP;
        else
            vc = VC_UNKNOWN;

        bad = 1'b0;
        priority if (!scan_upd.term_found || scan_upd.token_count != 3'd3)
        begin
            bad         = 1'b1;
            status_next = ST_BAD;
        end
        else if (scan_upd.path_count >= path_limit)
            status_next = ST_TOO_LONG;
        else if (!scan_upd.path_slash_first || vc == VC_UNKNOWN)
        begin
            bad         = 1'b1;
            status_next = ST_BAD;
        end
        else if (scan_upd.trav_found)
            status_next = ST_FORBIDDEN;
        else if (mc == MC_UNKNOWN)
            status_next = ST_NOT_IMPL;
        else if (vc == VC_UNSUPP)
            status_next = ST_VERSION;
        else if (mc == MC_POST)
            status_next = ST_NOT_IMPL;
        else
            status_next = ST_OK;

        valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status_next;
            method_reg  <= bad ? MC_UNKNOWN : mc;
            version_reg <= bad ? VC_UNKNOWN : vc;
            offset_reg  <= scan_upd.path_start;
            length_reg  <= scan_upd.path_count;
        end
    end

    assign res.valid        = valid_reg;
    assign res.status       = status_reg;
    assign res.method_code  = method_reg;
    assign res.version_code = version_reg;
    assign res.path_offset  = offset_reg;
    assign res.path_length  = length_reg;

    `HRLC_ASSERT_NEXT(a_load_shows_result, load, valid_reg)
    `HRLC_ASSERT_NOW(a_bad_clears_codes, valid_reg && status_reg == ST_BAD,
                     method_reg == MC_UNKNOWN && version_reg == VC_UNKNOWN)

endmodule

// ===== hw/rtl/http_request_line_checker_unit.sv =====
// Top level of the request line checker: input stage, tracker and verdict.
// Depends on hrlc_pkg, hrlc_stream_if, hrlc_tracker, hrlc_verdict.
//
// Checks an HTTP/1.x request presented one byte per beat on req, the final
// byte of each buffer flagged by last_byte. Bytes after the first zero byte,
// or beyond MAX_REQUEST_BYTES, are ignored; the flagged byte still closes the
// buffer. One verdict beat leaves on res for every flagged byte: status,
// method and version codes, and the offset and length of the path token.
// The block takes one byte every cycle while no flagged byte waits on res. A
// byte sits in the input register, where the running match state is advanced;
// a flagged byte loads the result register at the edge that advances it, and
// the verdict shows on res from there. The result register parts the two
// sides: while a verdict waits on res, the next flagged byte holds in the
// input register and the beats behind it wait; ordinary bytes never wait on res.
// path_limit (reset 4096) is written through cfg_wr_en/cfg_wr_data and must
// only change while no request is in flight.
`include "http_request_line_checker_unit_assert.svh"

module http_request_line_checker_unit import hrlc_pkg::*; #(
    parameter int MAX_REQUEST_BYTES = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    hrlc_req_if.sink           req,
    hrlc_res_if.source         res
);

    logic [LIMIT_W-1:0] path_limit_reg;

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;
    logic              req_fire;

    scan_state_t scan_upd;

    // Advance the held byte unless it closes a buffer and the previous
    // verdict still waits on res.
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !res.valid || res.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            path_limit_reg <= PATH_LIMIT_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
                path_limit_reg <= cfg_wr_data;
        end
    end

    // hold the payload until the stage drains
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_byte_reg <= req.data_byte;
            s1_last_reg <= req.last_byte;
        end
    end

    hrlc_tracker #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_adv),
        .last       (s1_last_reg),
        .data_byte  (s1_byte_reg),
        .path_limit (path_limit_reg),
        .scan_upd   (scan_upd)
    );

    hrlc_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_adv && s1_last_reg),
        .scan_upd   (scan_upd),
        .path_limit (path_limit_reg),
        .res        (res)
    );

    `HRLC_ASSERT_NOW(a_plain_byte_never_stalls, s1_valid_reg && !s1_last_reg, req.ready)

endmodule

// ===== test/http_request_line_checker_unit_tb.sv =====
// Self-checking testbench for http_request_line_checker_unit: drives request bytes,
// predicts every verdict in a scoreboard class and compares it field by field.
// Depends on hrlc_pkg, hrlc_stream_if and the checker RTL.
module http_request_line_checker_unit_tb;
    import hrlc_pkg::*;

    localparam int MAX_BYTES = 8192;

    // One verdict beat as it leaves on res
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [METHOD_W-1:0]  method_code;
        logic [VERSION_W-1:0] version_code;
        logic [OFFSET_W-1:0]  path_offset;
        logic [LIMIT_W-1:0]   path_length;
    } verdict_t;

    // Scoreboard: mirrors the scan state of the checker byte by byte and keeps
    // the verdicts still owed by the block, oldest first.
    class verdict_board;
        verdict_t           expected_verdicts[$];
        int unsigned        errors;
        logic [LIMIT_W-1:0] path_limit;

        string              method_text[3];
        logic [METHOD_W-1:0] method_codes[3];
        string              version_text[4];

        int unsigned byte_pos;
        int unsigned token_count;
        bit          in_token;
        bit          line_done;
        bit          cr_held;
        logic [2:0]  m_live;
        int unsigned m_pos;
        logic [3:0]  v_live;
        int unsigned v_pos;
        int unsigned path_start;
        int unsigned path_count;
        bit          slash_first;
        int unsigned dots;
        bit          traversal;
        int unsigned crlf_prog;
        bit          crlf_found;
        bit          nul_seen;

        function new();
            method_text  = '{"GET", "POST", "HEAD"};
            method_codes = '{MC_GET, MC_POST, MC_HEAD};
            version_text = '{"HTTP/1.0", "HTTP/1.1", "HTTP/0.9", "HTTP/2.0"};
            path_limit   = PATH_LIMIT_RESET;
            errors       = 0;
            restart();
        endfunction

        function void restart();
            byte_pos    = 0;
            token_count = 0;
            in_token    = 0;
            line_done   = 0;
            cr_held     = 0;
            m_live      = 3'b111;
            m_pos       = 0;
            v_live      = 4'b1111;
            v_pos       = 0;
            path_start  = 0;
            path_count  = 0;
            slash_first = 0;
            dots        = 0;
            traversal   = 0;
            crlf_prog   = 0;
            crlf_found  = 0;
            nul_seen    = 0;
        endfunction

        function void match_method(logic [7:0] b);
            for (int c = 0; c < 3; c++)
                if (m_pos >= method_text[c].len() || b != method_text[c][m_pos])
                    m_live[c] = 1'b0;
            if (m_pos < 5)
                m_pos++;
        endfunction

        function void match_version(logic [7:0] b);
            for (int c = 0; c < 4; c++)
                if (v_pos >= 8 || b != version_text[c][v_pos])
                    v_live[c] = 1'b0;
            if (v_pos < 9)
                v_pos++;
        endfunction

        function void walk_path(logic [7:0] b);
            if (path_count < path_limit)
                path_count++;
            if (b == CH_DOT)
                dots = (dots >= 1) ? 2 : 1;
            else if (b == CH_SLASH && dots == 2) begin
                traversal = 1;
                dots      = 0;
            end
            else
                dots = 0;
        endfunction

        function void line_byte(logic [7:0] b, int unsigned pos);
            if (b == CH_SP) begin
                in_token = 0;
                return;
            end
            if (!in_token) begin
                in_token = 1;
                if (token_count < 4)
                    token_count++;
                if (token_count == 2) begin
                    path_start  = pos;
                    slash_first = (b == CH_SLASH);
                end
            end
            case (token_count)
                1:       match_method(b);
                2:       walk_path(b);
                3:       match_version(b);
                default: ;
            endcase
        endfunction

        function void track_blank_line(logic [7:0] b);
            if (b == ((crlf_prog % 2 == 0) ? CH_CR : CH_LF)) begin
                crlf_prog++;
                if (crlf_prog >= 4) begin
                    crlf_found = 1;
                    crlf_prog  = 0;
                end
            end
            else
                crlf_prog = (b == CH_CR) ? 1 : 0;
        endfunction

        function verdict_t judge();
            verdict_t             v;
            logic [METHOD_W-1:0]  mc;
            logic [VERSION_W-1:0] vc;
            bit                   bad;
            mc = MC_UNKNOWN;
            for (int c = 0; c < 3; c++)
                if (mc == MC_UNKNOWN && m_live[c] && m_pos == method_text[c].len())
                    mc = method_codes[c];
            if (v_pos != 8)
                vc = VC_UNKNOWN;
            else if (v_live[0])
                vc = VC_HTTP10;
            else if (v_live[1])
                vc = VC_HTTP11;
            else if (|v_live[3:2])
                vc = VC_UNSUPP;
            else
                vc = VC_UNKNOWN;

            bad = !crlf_found || token_count != 3;
            if (bad)
                v.status = ST_BAD;
            else if (path_count >= path_limit)
                v.status = ST_TOO_LONG;
            else if (!slash_first || vc == VC_UNKNOWN) begin
                bad      = 1;
                v.status = ST_BAD;
            end
            else if (traversal)
                v.status = ST_FORBIDDEN;
            else if (mc == MC_UNKNOWN)
                v.status = ST_NOT_IMPL;
            else if (vc == VC_UNSUPP)
                v.status = ST_VERSION;
            else if (mc == MC_POST)
                v.status = ST_NOT_IMPL;
            else
                v.status = ST_OK;

            v.method_code  = bad ? MC_UNKNOWN : mc;
            v.version_code = bad ? VC_UNKNOWN : vc;
            v.path_offset  = path_start[OFFSET_W-1:0];
            v.path_length  = path_count[LIMIT_W-1:0];
            return v;
        endfunction

        // Advance the scan by one accepted byte; a flagged byte closes the buffer.
        function void note_byte(logic [7:0] b, logic last);
            int unsigned pos;
            pos = byte_pos;
            if (!nul_seen && pos < MAX_BYTES) begin
                if (b == CH_NUL)
                    nul_seen = 1;
                else begin
                    track_blank_line(b);
                    if (!line_done) begin
                        if (cr_held && b == CH_LF) begin
                            cr_held   = 0;
                            line_done = 1;
                        end
                        else begin
                            if (cr_held) begin
                                cr_held = 0;
                                line_byte(CH_CR, pos - 1);
                            end
                            if (b == CH_CR)
                                cr_held = 1;
                            else
                                line_byte(b, pos);
                        end
                    end
                end
                byte_pos = pos + 1;
            end
            if (last) begin
                expected_verdicts.push_back(judge());
                restart();
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (expected_verdicts.size() == 0) begin
                errors++;
                $display("%0t: verdict with none expected, actual %p", $time, got);
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("method_code", want.method_code, got.method_code);
            compare_field("version_code", want.version_code, got.version_code);
            compare_field("path_offset", want.path_offset, got.path_offset);
            compare_field("path_length", want.path_length, got.path_length);
        endfunction

        function void close_out();
            if (expected_verdicts.size() != 0) begin
                errors++;
                $display("%0t: %0d verdicts never arrived, expected first %p",
                         $time, expected_verdicts.size(), expected_verdicts[0]);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    hrlc_req_if req_bus ();
    hrlc_res_if res_bus ();

    http_request_line_checker_unit #(
        .MAX_REQUEST_BYTES (MAX_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .res         (res_bus)
    );

    verdict_board board = new();

    // Idling odds in percent per beat, changed from phase to phase
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    // Long hold-off on the result side; the sink process counts it down
    int unsigned sink_hold_left;
    int unsigned bytes_sent;

    // Request buffer under construction
    logic [7:0] frame[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous fixed limit, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // Watch both channels at every edge. Note the input beat before checking the
    // result beat so that a same-edge pair is seen in the right order.
    always @(posedge clk)
    begin : watch_beats
        verdict_t seen;
        if (rst_n) begin
            if (req_bus.valid && req_bus.ready)
                board.note_byte(req_bus.data_byte, req_bus.last_byte);
            if (res_bus.valid && res_bus.ready) begin
                seen.status       = res_bus.status;
                seen.method_code  = res_bus.method_code;
                seen.version_code = res_bus.version_code;
                seen.path_offset  = res_bus.path_offset;
                seen.path_length  = res_bus.path_length;
                board.check_verdict(seen);
            end
        end
    end

    // Result side: a long hold when asked for, otherwise random stall bursts.
    initial
    begin : verdict_sink
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (sink_hold_left != 0) begin
                res_bus.ready <= 1'b0;
                while (sink_hold_left != 0) begin
                    @(posedge clk);
                    sink_hold_left--;
                end
            end
            else if ($urandom_range(0, 99) < sink_idle_pct) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else begin
                res_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one byte, maybe after an idle burst, and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.data_byte <= b;
        req_bus.last_byte <= last;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i]);
    endfunction

    function automatic void put_crlf();
        frame.push_back(CH_CR);
        frame.push_back(CH_LF);
    endfunction

    // Request line, blank line, send
    task automatic send_line(string s);
        put_text(s);
        put_crlf();
        put_crlf();
        send_frame();
    endtask

    // Drop valid and wait for every owed verdict, then let the pipeline empty.
    task automatic drain_verdicts();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        board.path_limit = value;
    endtask

    // Biased towards the characters that steer the scan
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_SP;
            3:       return CH_DOT;
            4:       return CH_SLASH;
            5:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void put_letter();
        frame.push_back(8'(8'h61 + $urandom_range(0, 25)));
    endfunction

    function automatic void put_spaces();
        int n;
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) frame.push_back(CH_SP);
    endfunction

    // A mostly well-formed request with random content. Path lengths sit around
    // the limit when the limit is small enough to reach.
    function automatic void build_request();
        int          n;
        int unsigned lim;
        lim = board.path_limit;
        if ($urandom_range(0, 9) == 0)
            frame.push_back(CH_SP);
        case ($urandom_range(0, 7))
            0, 1, 2: put_text("GET");
            3:       put_text("POST");
            4:       put_text("HEAD");
            5:       put_text("GE");
            6:       put_text("HEADS");
            default: repeat ($urandom_range(1, 5)) frame.push_back(8'(8'h41 + $urandom_range(0, 25)));
        endcase
        put_spaces();

        if (lim <= 64 && $urandom_range(0, 2) == 0)
            n = $urandom_range(lim + 1, (lim > 0) ? lim - 1 : 0);
        else
            n = $urandom_range(1, 10);
        if (n > 0) begin
            if ($urandom_range(0, 9) != 0)
                frame.push_back(CH_SLASH);
            else
                frame.push_back(noise_byte());
            n--;
            if (n >= 3 && $urandom_range(0, 7) == 0) begin
                put_text("../");
                n -= 3;
            end
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0, 1:    frame.push_back(CH_DOT);
                    2:       frame.push_back(CH_SLASH);
                    default: put_letter();
                endcase
            end
        end
        put_spaces();

        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_text("HTTP/1.1");
            4, 5:       put_text("HTTP/1.0");
            6:          put_text("HTTP/0.9");
            7:          put_text("HTTP/2.0");
            8:          put_text("HTTP/1.");
            default:
            begin
                put_text("HTTP/1.1");
                frame.push_back(noise_byte());
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            frame.push_back(CH_SP);

        if ($urandom_range(0, 9) != 0)
            put_crlf();
        else if ($urandom_range(0, 1) == 0)
            frame.push_back(CH_CR);
        repeat ($urandom_range(0, 2)) begin
            put_text("X-");
            put_letter();
            put_text(": v");
            put_crlf();
        end
        if ($urandom_range(0, 9) != 0)
            put_crlf();
        if ($urandom_range(0, 24) == 0)
            frame.insert($urandom_range(0, frame.size() - 1), CH_NUL);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) frame.push_back(noise_byte());
    endfunction

    // Mostly well-formed requests, some corrupted ones and some pure noise,
    // until both the byte count and the buffer count are reached.
    task automatic run_random(input int unsigned nbytes, input int unsigned nframes);
        int unsigned start;
        int unsigned frames;
        int unsigned kind;
        int unsigned idx;
        start  = bytes_sent;
        frames = 0;
        while (bytes_sent - start < nbytes || frames < nframes) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                build_request();
                if (kind >= 70) begin
                    repeat ($urandom_range(1, 2)) begin
                        idx = $urandom_range(0, frame.size() - 1);
                        if ($urandom_range(0, 1) == 0 || frame.size() < 2)
                            frame[idx] = noise_byte();
                        else
                            frame.delete(idx);
                    end
                end
            end
            else
                repeat ($urandom_range(1, 24)) frame.push_back(noise_byte());
            send_frame();
            frames++;
        end
    endtask

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.data_byte <= '0;
        req_bus.last_byte <= 1'b0;
        src_idle_pct      = 20;
        sink_idle_pct     = 20;
        sink_hold_left    = 0;
        bytes_sent        = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset limit: each verdict but too-long and each
        // method and version code, then the awkward corners of the scan.
        send_line("GET /index.html HTTP/1.1");
        send_line("HEAD / HTTP/1.0");
        send_line("POST /form HTTP/1.1");
        send_line("PUT /x HTTP/1.1");
        send_line("GET /x HTTP/2.0");
        send_line("HEAD /x HTTP/0.9");
        send_line("GET /a/../b HTTP/1.0");
        send_line("GET x HTTP/1.1");
        send_line("GET /x HTTP/1.2");
        send_line("GET /x HTTP/1.10");
        send_line("GETX /x HTTP/1.1");
        send_line("  GET   /x  HTTP/1.1 ");
        send_line("GET /x HTTP/1.1 extra");
        send_line("GET");
        // no blank line after the request line
        put_text("GET / HTTP/1.1");
        put_crlf();
        send_frame();
        // blank line found only in the headers
        put_text("GET /h HTTP/1.1");
        put_crlf();
        put_text("Host: a");
        put_crlf();
        put_crlf();
        send_frame();
        // zero byte mid-line: the rest of the buffer is ignored
        put_text("GET /z");
        frame.push_back(CH_NUL);
        put_text(" HTTP/1.1");
        put_crlf();
        put_crlf();
        send_frame();
        // lone CR inside the path counts as a path byte
        put_text("GET /a");
        frame.push_back(CH_CR);
        put_text("b HTTP/1.1");
        put_crlf();
        put_crlf();
        send_frame();
        // lone CR opening the path moves the path offset back by one
        put_text("GET ");
        frame.push_back(CH_CR);
        put_text("/a HTTP/1.1");
        put_crlf();
        put_crlf();
        send_frame();
        // one-byte buffers at both ends of the byte range
        frame.push_back(8'hFF);
        send_frame();
        frame.push_back(CH_NUL);
        send_frame();
        drain_verdicts();

        // Long paths either side of a limit of 40; the longer one saturates
        write_limit(13'd40);
        src_idle_pct  = 5;
        sink_idle_pct = 10;
        put_text("GET /");
        repeat (38) frame.push_back("a");
        put_text(" HTTP/1.1");
        put_crlf();
        put_crlf();
        send_frame();
        put_text("GET /");
        repeat (44) frame.push_back("a");
        put_text(" HTTP/1.1");
        put_crlf();
        put_crlf();
        send_frame();
        drain_verdicts();

        // Smallest legal limit
        write_limit(13'd2);
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        run_random(120, 4);
        drain_verdicts();

        // Limits below the legal range: zero makes every path too long
        write_limit(13'd0);
        src_idle_pct  = 0;
        sink_idle_pct = 40;
        run_random(80, 3);
        drain_verdicts();

        write_limit(13'd1);
        src_idle_pct  = 40;
        sink_idle_pct = 0;
        run_random(80, 3);
        drain_verdicts();

        // Widest value the register holds
        write_limit({LIMIT_W{1'b1}});
        src_idle_pct  = 15;
        sink_idle_pct = 15;
        run_random(120, 4);
        drain_verdicts();

        // Small random limit. Hold results off for a long stretch first: the
        // verdict register stays full and the next flagged byte backs up req.
        write_limit(LIMIT_W'($urandom_range(3, 48)));
        src_idle_pct   = 20;
        sink_idle_pct  = 20;
        sink_hold_left = 150;
        run_random(80, 4);
        run_random(200, 6);
        drain_verdicts();

        // Back to the reset value, then a final stretch with no idling at all
        write_limit(PATH_LIMIT_RESET);
        src_idle_pct  = 10;
        sink_idle_pct = 25;
        run_random(200, 6);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(150, 5);
        drain_verdicts();
        repeat (4) @(posedge clk);

        board.close_out();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
